// ===== rtl/fpv_pkg.sv =====
package fpv_pkg;

    localparam int TRACKS      = 32;
    localparam int TRACK_W     = $clog2(TRACKS);
    localparam int FRAME_W     = 24;
    localparam int POS_W       = 16;
    localparam int VEL_W       = 22;
    localparam int HIST_LEN    = 4;
    localparam int FILL_W      = 3;
    localparam int SLOT_W      = 2;
    localparam int NUM_W       = 21;
    localparam int MAG_W       = 20;

    // floor(m / 15) = (m * RECIP_15) >> RECIP_SHIFT, exact for m below 2^20
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(((1 << RECIP_SHIFT) + 14) / 15);

    localparam logic [VEL_W:0] VEL_MAX_MAG = (VEL_W+1)'((1 << (VEL_W - 1)) - 1);
    localparam logic [VEL_W:0] VEL_MIN_MAG = (VEL_W+1)'(1 << (VEL_W - 1));

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 80;

    typedef struct packed {
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } sample_t;

    typedef sample_t [HIST_LEN-1:0] hist_t;

    // (p0 - 8 p1 + 8 p3 - p4) * 256 / 240, truncated toward zero, saturated
    function automatic logic signed [VEL_W-1:0] five_point_rate(
        input logic signed [POS_W-1:0] p0,
        input logic signed [POS_W-1:0] p1,
        input logic signed [POS_W-1:0] p3,
        input logic signed [POS_W-1:0] p4
    );
        logic signed [NUM_W-1:0]       num;
        logic                          neg;
        logic [MAG_W-1:0]              mag;
        logic [MAG_W+RECIP_W-1:0]      prod;
        logic [VEL_W:0]                q_mag;
        logic signed [VEL_W:0]         q;
        num  = NUM_W'(p0) - NUM_W'(p4) + (NUM_W'(p3) <<< 3) - (NUM_W'(p1) <<< 3);
        neg  = num[NUM_W-1];
        mag  = neg ? MAG_W'(-num) : MAG_W'(num);
        prod = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(RECIP_15);
        // 16 m / 15 = m + m / 15
        q_mag = (VEL_W+1)'(mag) + (VEL_W+1)'(prod[MAG_W+RECIP_W-1:RECIP_SHIFT]);
        if (!neg) begin
            q = (q_mag > VEL_MAX_MAG) ? $signed(VEL_MAX_MAG) : $signed(q_mag);
        end else begin
            q = (q_mag > VEL_MIN_MAG) ? -$signed(VEL_MIN_MAG) : -$signed(q_mag);
        end
        return q[VEL_W-1:0];
    endfunction

endpackage

// ===== rtl/five_point_velocity_per_track.sv =====
// channel | ports          | payload, lowest bit first
// --------+----------------+------------------------------------------------------
// sample  | s_tvalid/ready | tdata: frame_number, track_id, pos_x, pos_y; tuser: first_of_frame
// rate    | m_tvalid/ready | tdata: rate_valid, rate_track, rate_frame, vel_x, vel_y
//
// one sample per cycle unless a waiting beat stalls; a result beat passes two registers
// (input register, then history read-modify-write and rate math into the output register)
// a sample yields a beat only once its track already holds four samples
// aresetn clears all fill counts and sets the frame memory so frame 0 continues
// a beat waiting with m_tready low lets the input register take one more sample,
// then s_tready drops
module five_point_velocity_per_track (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame_number[23:0], track_id[28:24], pos_x[44:29], pos_y[60:45], zero pad
    input  logic [fpv_pkg::S_TDATA_W-1:0]   s_tdata,
    // first_of_frame[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // rate_valid[0], rate_track[5:1], rate_frame[29:6], vel_x[51:30], vel_y[73:52], zero pad
    output logic [fpv_pkg::M_TDATA_W-1:0]   m_tdata
);
    import fpv_pkg::*;

    logic                       in_valid_reg;
    logic [FRAME_W-1:0]         in_frame_reg;
    logic                       in_first_reg;
    logic [TRACK_W-1:0]         in_track_reg;
    sample_t                    in_sample_reg;

    logic                       out_valid_reg;
    logic [M_TDATA_W-1:0]       out_data_reg;

    logic [FRAME_W:0]           last_frame_reg;
    logic [FILL_W-1:0]          fill_count_reg [TRACKS];
    hist_t                      hist_mem [TRACKS];

    logic                       adv;
    logic                       proc;
    logic                       brk;
    logic [FILL_W-1:0]          eff_fill;
    logic                       produce;
    hist_t                      hist_rd;
    logic signed [VEL_W-1:0]    vel_x;
    logic signed [VEL_W-1:0]    vel_y;
    logic [FRAME_W-1:0]         rate_frame;
    logic [M_TDATA_W-1:0]       out_data_next;

    assign adv      = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;

    // continuity check only on the first sample of a frame
    assign brk      = in_first_reg && ({1'b0, in_frame_reg} != last_frame_reg + 1'b1);
    assign eff_fill = brk ? '0 : fill_count_reg[in_track_reg];
    assign produce  = (eff_fill == FILL_W'(HIST_LEN));
    assign hist_rd  = hist_mem[in_track_reg];

    assign vel_x = five_point_rate(hist_rd[0].x, hist_rd[1].x, hist_rd[3].x, in_sample_reg.x);
    assign vel_y = five_point_rate(hist_rd[0].y, hist_rd[1].y, hist_rd[3].y, in_sample_reg.y);
    assign rate_frame = in_frame_reg - FRAME_W'(2);

    assign out_data_next = {
        (M_TDATA_W - 1 - TRACK_W - FRAME_W - 2 * VEL_W)'(0),
        vel_y, vel_x, rate_frame, in_track_reg, 1'b1
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_frame_reg    <= s_tdata[FRAME_W-1:0];
            in_first_reg    <= s_tuser;
            in_track_reg    <= s_tdata[FRAME_W +: TRACK_W];
            in_sample_reg.x <= s_tdata[FRAME_W+TRACK_W +: POS_W];
            in_sample_reg.y <= s_tdata[FRAME_W+TRACK_W+POS_W +: POS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_frame_reg <= '1;
            for (int i = 0; i < TRACKS; i++) begin
                fill_count_reg[i] <= '0;
            end
        end else if (proc) begin
            last_frame_reg <= {1'b0, in_frame_reg};
            for (int i = 0; i < TRACKS; i++) begin
                if (i == int'(in_track_reg)) begin
                    if (!produce) begin
                        fill_count_reg[i] <= eff_fill + 1'b1;
                    end
                end else if (brk) begin
                    fill_count_reg[i] <= '0;
                end
            end
        end
    end

    // history store, no reset: fill count gates every read
    always_ff @(posedge aclk) begin
        if (proc) begin
            if (produce) begin
                hist_mem[in_track_reg] <= {in_sample_reg, hist_rd[3], hist_rd[2], hist_rd[1]};
            end else begin
                hist_mem[in_track_reg][eff_fill[SLOT_W-1:0]] <= in_sample_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= proc && produce;
        end
        if (proc && produce) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_break_no_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && brk |=> !out_valid_reg)
        else $error("beat produced after a frame break");

    a_frame_mem: assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> last_frame_reg == {1'b0, $past(in_frame_reg)})
        else $error("frame memory not updated");

    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !adv |=> in_valid_reg && $stable(in_frame_reg))
        else $error("held sample lost while output stalled");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !produce |=>
            fill_count_reg[$past(in_track_reg)] == $past(eff_fill) + 1'b1)
        else $error("fill count did not advance");

endmodule
